// ===== hw/rtl/packed_bitfield_gene_store_macros.svh =====
// assertion macros for the packed gene store
// used by the top level only, no other dependencies
`ifndef PACKED_BITFIELD_GENE_STORE_MACROS_SVH
`define PACKED_BITFIELD_GENE_STORE_MACROS_SVH

// same-cycle implication
`define PBGS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBGS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pbgs_pkg.sv =====
// constants, codes and payload types for the packed gene store
// no dependencies
package pbgs_pkg;

  localparam int MAX_GENES     = 1024;
  localparam int MAX_GENE_BITS = 8;
  localparam int STORE_BYTES   = MAX_GENES + 1;
  localparam int EVEN_DEPTH    = (STORE_BYTES + 1) / 2;
  localparam int ODD_DEPTH     = STORE_BYTES / 2;
  localparam int EVEN_AW       = $clog2(EVEN_DEPTH);
  localparam int ODD_AW        = $clog2(ODD_DEPTH);
  localparam int ADDR_W        = $clog2(MAX_GENES);

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 8;
  localparam int GW_W       = 4;
  localparam int CNT_W      = 11;
  localparam int BITPOS_W   = IDX_W + GW_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_VAL_W  = CNT_W;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GENE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENE_COUNT = 2'd1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] gene_idx;
    logic [VAL_W-1:0] gene_value;
  } pbgs_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             range_error;
  } pbgs_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } pbgs_cfg_t;

  // one located access
  typedef struct packed {
    logic               mode;
    logic               err;
    logic [VAL_W-1:0]   val;
    logic               hi_odd;
    logic [2:0]         off;
    logic [GW_W-1:0]    w;
    logic [EVEN_AW-1:0] even_idx;
    logic [ODD_AW-1:0]  odd_idx;
  } pbgs_op_t;

  // write-back of the two-byte window
  typedef struct packed {
    logic             hi_we;
    logic             lo_we;
    logic [VAL_W-1:0] hi_data;
    logic [VAL_W-1:0] lo_data;
  } pbgs_wr_t;

endpackage

// ===== hw/rtl/pbgs_stream_if.sv =====
// valid/ready channel with a typed payload
// payload types come from pbgs_pkg
interface pbgs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pbgs_bank.sv =====
// one byte bank of the gene store, one write and one registered read port
// no package dependencies
module pbgs_bank #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pbgs_locate.sv =====
// maps a gene index to its byte window, bit offset and range check
// depends on pbgs_pkg
module pbgs_locate
  import pbgs_pkg::*;
(
  input  pbgs_item_t       item,
  input  logic [GW_W-1:0]  gene_width,
  input  logic [CNT_W-1:0] gene_count,
  output pbgs_op_t         op
);

  logic [GW_W-1:0]     w;
  logic [CNT_W-1:0]    count_eff;
  logic [BITPOS_W-1:0] bitpos;
  logic [ADDR_W-1:0]   addr;
  logic [ADDR_W:0]     addr_p1;

  always_comb begin
    if (gene_width == '0) begin
      w = GW_W'(1);
    end else if (gene_width > GW_W'(MAX_GENE_BITS)) begin
      w = GW_W'(MAX_GENE_BITS);
    end else begin
      w = gene_width;
    end
    if (gene_count > CNT_W'(MAX_GENES)) begin
      count_eff = CNT_W'(MAX_GENES);
    end else begin
      count_eff = gene_count;
    end
    bitpos  = BITPOS_W'(item.gene_idx) * BITPOS_W'(w);
    addr    = bitpos[3 +: ADDR_W];
    addr_p1 = {1'b0, addr} + 1'b1;

    op.mode     = item.mode;
    op.err      = CNT_W'(item.gene_idx) >= count_eff;
    op.val      = item.gene_value;
    op.hi_odd   = addr[0];
    op.off      = bitpos[2:0];
    op.w        = w;
    op.even_idx = EVEN_AW'(addr_p1 >> 1);
    op.odd_idx  = ODD_AW'(addr >> 1);
  end

endmodule

// ===== hw/rtl/pbgs_merge.sv =====
// extracts or replaces one gene inside its two-byte window
// depends on pbgs_pkg
module pbgs_merge
  import pbgs_pkg::*;
(
  input  pbgs_op_t         op,
  input  logic [VAL_W-1:0] even_byte,
  input  logic [VAL_W-1:0] odd_byte,
  output pbgs_result_t     res,
  output pbgs_wr_t         wr
);

  logic [VAL_W-1:0]   hi;
  logic [VAL_W-1:0]   lo;
  logic [VAL_W-1:0]   mask8;
  logic [2*VAL_W-1:0] word;
  logic [2*VAL_W-1:0] mask16;
  logic [2*VAL_W-1:0] rd_word;
  logic [2*VAL_W-1:0] new_word;
  logic [GW_W-1:0]    span;

  always_comb begin
    hi       = op.hi_odd ? odd_byte : even_byte;
    lo       = op.hi_odd ? even_byte : odd_byte;
    word     = {hi, lo};
    mask8    = ~(8'hFF >> op.w);
    mask16   = {mask8, 8'h00} >> op.off;
    rd_word  = (word & mask16) << op.off;
    new_word = (word & ~mask16) | ({op.val & mask8, 8'h00} >> op.off);
    span     = {1'b0, op.off} + op.w;

    res.range_error = op.err;
    res.read_value  = (!op.err && op.mode == MODE_READ) ? rd_word[2*VAL_W-1:VAL_W] : '0;

    wr.hi_we   = !op.err && op.mode == MODE_WRITE;
    wr.lo_we   = wr.hi_we && (span > GW_W'(VAL_W));
    wr.hi_data = new_word[2*VAL_W-1:VAL_W];
    wr.lo_data = new_word[VAL_W-1:0];
  end

endmodule

// ===== hw/rtl/packed_bitfield_gene_store.sv =====
// Packed gene store: sustains one read or write beat per clock unless result
// back-pressure stalls it; an accepted item passes the s1 and s2 stage registers
// to the result register. The store is split into an even and an odd byte bank,
// each with one read and one write port, so the two bytes of a gene window are
// read together and written back together; a one-entry bypass per bank covers a
// read that follows a write. After reset a clearing pass zeroes both banks, during
// which no item is accepted; configuration writes are always taken.
`include "packed_bitfield_gene_store_macros.svh"

module packed_bitfield_gene_store
  import pbgs_pkg::*;
(
  input logic          clk,
  input logic          rst,
  pbgs_stream_if.sink   item,
  pbgs_stream_if.source result,
  pbgs_stream_if.sink   cfg
);

  logic [GW_W-1:0]  gene_width;
  logic [CNT_W-1:0] gene_count;

  logic               clearing;
  logic [EVEN_AW-1:0] clr_cnt;

  logic     s1_valid;
  pbgs_op_t s1_op;
  logic     s2_valid;
  pbgs_op_t s2_op;
  pbgs_op_t op_next;

  logic         res_valid;
  pbgs_result_t res_data;
  pbgs_result_t res_next;
  pbgs_wr_t     wr;

  logic s1_adv;
  logic s2_adv;
  logic item_ready_int;
  logic item_acc;

  logic               even_we;
  logic [EVEN_AW-1:0] even_waddr;
  logic [7:0]         even_wdata;
  logic [7:0]         even_rd;
  logic               odd_we;
  logic [ODD_AW-1:0]  odd_waddr;
  logic [7:0]         odd_wdata;
  logic [7:0]         odd_rd;

  logic               fe_valid;
  logic [EVEN_AW-1:0] fe_idx;
  logic [7:0]         fe_data;
  logic               fo_valid;
  logic [ODD_AW-1:0]  fo_idx;
  logic [7:0]         fo_data;
  logic [7:0]         even_byte;
  logic [7:0]         odd_byte;

  assign s2_adv         = s2_valid && (!res_valid || result.ready);
  assign s1_adv         = s1_valid && (!s2_valid || s2_adv);
  assign item_ready_int = !clearing && (!s1_valid || s1_adv);
  assign item_acc       = item.valid && item_ready_int;

  assign item.ready   = item_ready_int;
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gene_width <= GW_W'(MAX_GENE_BITS);
      gene_count <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_GENE_WIDTH: gene_width <= cfg.data.value[GW_W-1:0];
        REG_GENE_COUNT: gene_count <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == EVEN_AW'(EVEN_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  pbgs_locate u_locate (
    .item       (item.data),
    .gene_width (gene_width),
    .gene_count (gene_count),
    .op         (op_next)
  );

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_op <= op_next;
    end
    if (s1_adv) begin
      s2_op <= s1_op;
    end
    if (s2_adv) begin
      res_data <= res_next;
    end
  end

  pbgs_bank #(.DEPTH(EVEN_DEPTH), .AW(EVEN_AW)) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (s1_adv),
    .raddr (s1_op.even_idx),
    .rdata (even_rd)
  );

  pbgs_bank #(.DEPTH(ODD_DEPTH), .AW(ODD_AW)) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (s1_adv),
    .raddr (s1_op.odd_idx),
    .rdata (odd_rd)
  );

  // bypass of the write that landed on the read edge
  assign even_byte = (fe_valid && fe_idx == s2_op.even_idx) ? fe_data : even_rd;
  assign odd_byte  = (fo_valid && fo_idx == s2_op.odd_idx) ? fo_data : odd_rd;

  pbgs_merge u_merge (
    .op        (s2_op),
    .even_byte (even_byte),
    .odd_byte  (odd_byte),
    .res       (res_next),
    .wr        (wr)
  );

  always_comb begin
    if (clearing) begin
      even_we    = 1'b1;
      even_waddr = clr_cnt;
      even_wdata = '0;
      odd_we     = clr_cnt < EVEN_AW'(ODD_DEPTH);
      odd_waddr  = clr_cnt[ODD_AW-1:0];
      odd_wdata  = '0;
    end else begin
      even_we    = s2_adv && (s2_op.hi_odd ? wr.lo_we : wr.hi_we);
      even_waddr = s2_op.even_idx;
      even_wdata = s2_op.hi_odd ? wr.lo_data : wr.hi_data;
      odd_we     = s2_adv && (s2_op.hi_odd ? wr.hi_we : wr.lo_we);
      odd_waddr  = s2_op.odd_idx;
      odd_wdata  = s2_op.hi_odd ? wr.hi_data : wr.lo_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
      fo_valid <= 1'b0;
    end else if (!clearing) begin
      if (even_we) begin
        fe_valid <= 1'b1;
      end
      if (odd_we) begin
        fo_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clearing && even_we) begin
      fe_idx  <= even_waddr;
      fe_data <= even_wdata;
    end
    if (!clearing && odd_we) begin
      fo_idx  <= odd_waddr;
      fo_data <= odd_wdata;
    end
  end

  `PBGS_ASSERT_IMP(a_no_accept_clear, clk, rst, clearing, !item_ready_int, "item taken during clear")
  `PBGS_ASSERT_IMP(a_err_no_write, clk, rst, s2_valid && s2_op.err && !clearing, !even_we && !odd_we, "store written on range error")
  `PBGS_ASSERT_NXT(a_write_zero, clk, rst, s2_adv && s2_op.mode == MODE_WRITE, res_valid && res_data.read_value == '0, "write beat returned data")
  `PBGS_ASSERT_IMP(a_lo_needs_hi, clk, rst, s2_valid && !clearing && wr.lo_we, wr.hi_we, "second byte written alone")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for packed_bitfield_gene_store: directed and random gene reads and writes,
// checked against an in-bench model of the packed byte store and its two registers
// depends on pbgs_pkg and pbgs_stream_if
module testbench;
  import pbgs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int MAX_IDLE_GAP   = 13;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 145;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pbgs_stream_if #(.payload_t(pbgs_item_t))   item_ch ();
  pbgs_stream_if #(.payload_t(pbgs_result_t)) result_ch ();
  pbgs_stream_if #(.payload_t(pbgs_cfg_t))    cfg_ch ();

  packed_bitfield_gene_store uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [VAL_W-1:0] gene_mem_model [STORE_BYTES];
  logic [GW_W-1:0]  cur_gene_width;
  logic [CNT_W-1:0] cur_gene_count;
  pbgs_result_t     expected_results [$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  reads_sent = 0;
  int  writes_sent = 0;
  int  range_errors_sent = 0;
  int  cfg_writes = 0;
  int  idle_cycles = 0;
  bit  item_no_idle = 1'b0;
  bit  result_no_idle = 1'b0;

  function automatic pbgs_result_t apply_gene_access(input pbgs_item_t it);
    int               w, c, bitpos, addr, off;
    logic [7:0]       mask8;
    logic [15:0]      mask16, window, shifted;
    pbgs_result_t     res;
    res = '0;
    w = int'(cur_gene_width);
    if (w == 0) w = 1;
    if (w > MAX_GENE_BITS) w = MAX_GENE_BITS;
    c = int'(cur_gene_count);
    if (c > MAX_GENES) c = MAX_GENES;
    if (int'(it.gene_idx) >= c) begin
      res.range_error = 1'b1;
      return res;
    end
    bitpos = int'(it.gene_idx) * w;
    addr   = bitpos >> 3;
    off    = bitpos & 7;
    mask8  = 8'hFF << (8 - w);
    mask16 = {8'h00, mask8} << (8 - off);
    window = {gene_mem_model[addr], gene_mem_model[addr + 1]};
    if (it.mode == MODE_READ) begin
      shifted = (window & mask16) << off;
      res.read_value = shifted[15:8];
    end else begin
      window = (window & ~mask16) | ({8'h00, it.gene_value & mask8} << (8 - off));
      gene_mem_model[addr] = window[15:8];
      if (off + w > 8) gene_mem_model[addr + 1] = window[7:0];
    end
    return res;
  endfunction

  task automatic send_gene_access(input logic mode, input int idx, input logic [7:0] val);
    pbgs_item_t   it;
    pbgs_result_t res;
    int unsigned  gap;
    it.mode       = mode;
    it.gene_idx   = idx[IDX_W-1:0];
    it.gene_value = val;
    gap = item_no_idle ? 0 : $urandom_range(0, MAX_IDLE_GAP);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.data  = it;
    do @(posedge clk); while (!item_ch.ready);
    res = apply_gene_access(it);
    expected_results.push_back(res);
    if (res.range_error) range_errors_sent++;
    if (mode == MODE_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    pbgs_cfg_t beat;
    beat.index = idx;
    beat.value = value[CFG_VAL_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = beat;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_GENE_WIDTH: cur_gene_width = beat.value[GW_W-1:0];
      REG_GENE_COUNT: cur_gene_count = beat.value[CNT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_geometry(input int width_val, input int count_val);
    wait_drained();
    write_reg(REG_GENE_WIDTH, width_val);
    write_reg(REG_GENE_COUNT, count_val);
  endtask

  task automatic test_reset_defaults;
    send_gene_access(MODE_READ, 0, 8'h00);
    send_gene_access(MODE_WRITE, 1023, 8'hFF);
  endtask

  task automatic test_range_limits;
    set_geometry(8, MAX_GENES);
    send_gene_access(MODE_WRITE, 0, 8'hFF);
    send_gene_access(MODE_WRITE, 1023, 8'hA5);
    send_gene_access(MODE_READ, 1023, 8'h00);
    send_gene_access(MODE_READ, 0, 8'h00);
    send_gene_access(MODE_READ, 1, 8'hFF);
    set_geometry(8, 2047);
    send_gene_access(MODE_READ, 1023, 8'h00);
    set_geometry(8, 1);
    send_gene_access(MODE_READ, 1, 8'h00);
    send_gene_access(MODE_WRITE, 1, 8'h3C);
    send_gene_access(MODE_READ, 0, 8'h00);
    set_geometry(8, MAX_GENES);
    send_gene_access(MODE_READ, 1, 8'h00);
  endtask

  task automatic test_width_clamp;
    set_geometry(0, MAX_GENES);
    send_gene_access(MODE_WRITE, 3, 8'h80);
    send_gene_access(MODE_READ, 3, 8'h00);
    send_gene_access(MODE_READ, 2, 8'h00);
    set_geometry(15, MAX_GENES);
    send_gene_access(MODE_READ, 0, 8'h00);
    // upper register bits set, low nibble nine
    set_geometry('h7F9, MAX_GENES);
    send_gene_access(MODE_READ, 1023, 8'h00);
  endtask

  task automatic test_spanning_genes;
    set_geometry(3, MAX_GENES);
    send_gene_access(MODE_WRITE, 2, 8'hFF);
    send_gene_access(MODE_READ, 2, 8'h00);
    send_gene_access(MODE_READ, 1, 8'h00);
    send_gene_access(MODE_WRITE, 5, 8'h5F);
    send_gene_access(MODE_READ, 5, 8'h00);
  endtask

  task automatic test_spare_registers;
    wait_drained();
    write_reg(REG_SPARE_2, 'h7FF);
    write_reg(REG_SPARE_3, 0);
    send_gene_access(MODE_READ, 2, 8'h00);
  endtask

  task automatic run_random_phase(input int n_items);
    int w_sel, c_sel, wval, cval, eff_cnt, base, span, idx, k, j;
    w_sel = $urandom_range(0, 9);
    if (w_sel == 0) wval = 0;
    else if (w_sel == 1) wval = $urandom_range(9, 15);
    else wval = $urandom_range(1, 8);
    c_sel = $urandom_range(0, 9);
    if (c_sel == 0) cval = MAX_GENES;
    else if (c_sel == 1) cval = $urandom_range(MAX_GENES + 1, 2047);
    else if (c_sel == 2) cval = $urandom_range(1, 8);
    else cval = $urandom_range(1, MAX_GENES);
    set_geometry(($urandom_range(0, 127) << GW_W) | wval, cval);
    eff_cnt = (cval > MAX_GENES) ? MAX_GENES : cval;
    k = 0;
    while (k < n_items) begin
      item_no_idle   = ($urandom_range(0, 3) == 0);
      result_no_idle = ($urandom_range(0, 3) == 0);
      span = $urandom_range(0, 15);
      base = $urandom_range(0, eff_cnt - 1);
      for (j = 0; j < 24 && k < n_items; j++) begin
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, MAX_GENES - 1);
        else idx = (base + $urandom_range(0, span)) % eff_cnt;
        send_gene_access($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, idx,
                         8'($urandom_range(0, 255)));
        k++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    item_no_idle   = 1'b0;
    result_no_idle = 1'b0;
  endtask

  task automatic test_random_traffic;
    repeat (RANDOM_PHASES) run_random_phase(PHASE_ITEMS);
  endtask

  task automatic test_drain_pause;
    int n;
    set_geometry(5, 64);
    item_no_idle = 1'b1;
    for (n = 0; n < 30; n++)
      send_gene_access($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                       $urandom_range(0, 70), 8'($urandom_range(0, 255)));
    // hold the sender until the result stream is empty
    wait_drained();
    for (n = 0; n < 10; n++)
      send_gene_access($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                       $urandom_range(0, 63), 8'($urandom_range(0, 255)));
    item_no_idle = 1'b0;
  endtask

  initial begin
    int unsigned gap;
    result_ch.ready = 1'b0;
    forever begin
      gap = result_no_idle ? 0 : $urandom_range(0, MAX_IDLE_GAP);
      @(negedge clk);
      if (gap > 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    pbgs_result_t exp_res;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: read_value=%02h range_error=%0b",
                   result_ch.data.read_value, result_ch.data.range_error);
      end else begin
        exp_res = expected_results.pop_front();
        if (result_ch.data.read_value !== exp_res.read_value ||
            result_ch.data.range_error !== exp_res.range_error) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d: expected read_value=%02h range_error=%0b, got %02h %0b",
                     results_checked, exp_res.read_value, exp_res.range_error,
                     result_ch.data.read_value, result_ch.data.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    foreach (gene_mem_model[i]) gene_mem_model[i] = '0;
    cur_gene_width = GW_W'(8);
    cur_gene_count = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_range_limits();
    test_width_clamp();
    test_spanning_genes();
    test_spare_registers();
    test_drain_pause();
    test_random_traffic();
    wait_drained();

    $display("covered %0d gene reads and %0d gene writes, %0d of them out of range",
             reads_sent, writes_sent, range_errors_sent);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             cfg_writes, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
